>>> hdl/tnhr_pkg.sv
// ----------------------------------------------------------------------------
// tnhr_pkg
// Shared types, constants and helpers for the TCP NAT header rewrite block.
// ----------------------------------------------------------------------------
package tnhr_pkg;

  localparam int SERVER_ENTRIES_DEF   = 8;
  localparam int CLIENT_ENTRIES_DEF   = 1024;
  localparam int MAX_PACKET_BYTES_DEF = 65535;

  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 10;
  localparam int IP_W     = 32;
  localparam int PORT_W   = 16;
  localparam int ENTRY_W  = IP_W + PORT_W;
  localparam int LEN_W    = 16;
  localparam int HW_W     = 4;
  localparam int IPS_W    = 20;
  localparam int TCS_W    = 32;
  localparam int LIM_W    = LEN_W + 1;

  // input kinds
  localparam logic [1:0] MODE_PKT = 2'd0;
  localparam logic [1:0] MODE_SRV = 2'd1;
  localparam logic [1:0] MODE_CLI = 2'd2;

  // configuration register indexes
  localparam logic CFG_BAL_IP   = 1'b0;
  localparam logic CFG_BAL_PORT = 1'b1;

  // byte positions within the packet
  localparam int POS_VER_IHL   = 0;
  localparam int POS_LEN_HI    = 2;
  localparam int POS_LEN_LO    = 3;
  localparam int IP_SUM_END    = 10;
  localparam int IP_HDR_BYTES  = 20;
  localparam int TCP_SUM_START = 24;
  localparam int TCP_CSUM_HI   = 36;
  localparam int TCP_CSUM_LO   = 37;

  localparam logic [15:0] TCP_PROTO = 16'd6;
  localparam logic [15:0] ONES16    = 16'hffff;

  typedef struct packed {
    logic [IPS_W-1:0] ip_sum;
    logic [TCS_W-1:0] tcp_sum;
    logic [LEN_W-1:0] tot_len;
    logic [HW_W-1:0]  hdr_words;
    logic [LEN_W-1:0] count;
  } pkt_sum_t;

  typedef struct packed {
    logic [IP_W-1:0]   src_ip;
    logic [IP_W-1:0]   dst_ip;
    logic [PORT_W-1:0] src_port;
    logic [PORT_W-1:0] dst_port;
    logic [15:0]       ip_csum;
    logic [15:0]       tcp_csum;
    logic              short_pkt;
  } result_t;

  function automatic logic [LEN_W-1:0] tcp_len(input logic [LEN_W-1:0] tot,
                                               input logic [HW_W-1:0] hw);
    logic [LEN_W-1:0] hl;
    hl = LEN_W'({hw, 2'b00});
    return (tot >= hl) ? (tot - hl) : '0;
  endfunction

endpackage

>>> hdl/tcp_nat_header_rewrite_top.sv
// ----------------------------------------------------------------------------
// tcp_nat_header_rewrite_top
// IPv4/TCP NAT rewrite: new addresses, ports and both recomputed checksums.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while s_tready is high: a packet byte, or a write to
// the server or client destination table. Packet bytes are summed as they
// arrive; the destination entry is read from its table RAM (registered read
// data) on the first byte of each packet and held for the packet. One result
// beat is presented for each packet once its last byte is accepted, through a
// four-stage result pipeline that keeps accepting while results wait on the
// output, until all four stages hold a result. Sustained rate is one beat per
// cycle while the output is not stalled, set by the byte accumulator. Table
// contents are undefined until written; a lookup beyond a table's depth gives zero.
// ----------------------------------------------------------------------------
module tcp_nat_header_rewrite_top import tnhr_pkg::*; #(
  parameter int SERVER_ENTRIES   = SERVER_ENTRIES_DEF,
  parameter int CLIENT_ENTRIES   = CLIENT_ENTRIES_DEF,
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // data_byte[7:0], dest_index[17:8], entry_ip[49:18], entry_port[65:50]
  input  logic [71:0]  s_tdata,
  // mode[1:0], toward_server[2]
  input  logic [2:0]   s_tuser,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_src_ip[31:0], new_dst_ip[63:32], new_src_port[79:64],
  // new_dst_port[95:80], ip_header_sum[111:96], tcp_segment_sum[127:112]
  output logic [127:0] m_tdata,
  // short_packet[0]
  output logic [0:0]   m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  logic               accept;
  logic               pkt_beat;
  logic               first;
  logic [1:0]         mode;
  logic [IDX_W-1:0]   dest_index;
  logic [ENTRY_W-1:0] wentry;
  logic [ENTRY_W-1:0] entry;
  logic [IP_W-1:0]    bal_ip;
  logic [PORT_W-1:0]  bal_port;
  pkt_sum_t           summary;
  result_t            result;

  assign mode       = s_tuser[1:0];
  assign dest_index = s_tdata[17:8];
  assign wentry     = {s_tdata[49:18], s_tdata[65:50]};
  assign accept     = s_tvalid && s_tready;
  assign pkt_beat   = accept && (mode == MODE_PKT);
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bal_ip   <= '0;
      bal_port <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BAL_IP:   bal_ip   <= cfg_data;
        CFG_BAL_PORT: bal_port <= cfg_data[PORT_W-1:0];
        default:      bal_ip   <= bal_ip;
      endcase
    end
  end

  tnhr_acc #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_acc (
    .clk       (clk),
    .rst       (rst),
    .beat      (pkt_beat),
    .last      (s_tlast),
    .data_byte (s_tdata[7:0]),
    .first     (first),
    .summary   (summary)
  );

  tnhr_lookup #(
    .SERVER_ENTRIES (SERVER_ENTRIES),
    .CLIENT_ENTRIES (CLIENT_ENTRIES)
  ) u_lookup (
    .clk    (clk),
    .rst    (rst),
    .wr_srv (accept && (mode == MODE_SRV)),
    .wr_cli (accept && (mode == MODE_CLI)),
    .rd     (first),
    .dir    (s_tuser[2]),
    .index  (dest_index),
    .wentry (wentry),
    .entry  (entry)
  );

  tnhr_fin u_fin (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pkt_beat && s_tlast),
    .in_ready  (s_tready),
    .summary   (summary),
    .entry     (entry),
    .bal_ip    (bal_ip),
    .bal_port  (bal_port),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (result)
  );

  assign m_tdata = {result.tcp_csum, result.ip_csum, result.dst_port,
                    result.src_port, result.dst_ip, result.src_ip};
  assign m_tuser = result.short_pkt;

endmodule

>>> hdl/tnhr_ram.sv
// ----------------------------------------------------------------------------
// tnhr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tnhr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/tnhr_lookup.sv
// ----------------------------------------------------------------------------
// tnhr_lookup
// Server and client destination tables; entry chosen on the first packet beat.
// ----------------------------------------------------------------------------
module tnhr_lookup import tnhr_pkg::*; #(
  parameter int SERVER_ENTRIES = SERVER_ENTRIES_DEF,
  parameter int CLIENT_ENTRIES = CLIENT_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_srv,
  input  logic               wr_cli,
  input  logic               rd,
  input  logic               dir,
  input  logic [IDX_W-1:0]   index,
  input  logic [ENTRY_W-1:0] wentry,
  output logic [ENTRY_W-1:0] entry
);

  localparam int SAW = (SERVER_ENTRIES > 1) ? $clog2(SERVER_ENTRIES) : 1;
  localparam int CAW = (CLIENT_ENTRIES > 1) ? $clog2(CLIENT_ENTRIES) : 1;

  logic               srv_hit;
  logic               cli_hit;
  logic [SAW-1:0]     srv_addr;
  logic [CAW-1:0]     cli_addr;
  logic [ENTRY_W-1:0] srv_rdata;
  logic [ENTRY_W-1:0] cli_rdata;
  logic               pend;
  logic               pend_dir;
  logic               pend_hit;
  logic [ENTRY_W-1:0] looked;
  logic [ENTRY_W-1:0] chosen;

  assign srv_hit  = (32'(index) < SERVER_ENTRIES);
  assign cli_hit  = (32'(index) < CLIENT_ENTRIES);
  assign srv_addr = SAW'(index);
  assign cli_addr = CAW'(index);

  tnhr_ram #(.WIDTH(ENTRY_W), .DEPTH(SERVER_ENTRIES)) u_srv_ram (
    .clk   (clk),
    .we    (wr_srv && srv_hit),
    .waddr (srv_addr),
    .wdata (wentry),
    .re    (rd && dir),
    .raddr (srv_addr),
    .rdata (srv_rdata)
  );

  tnhr_ram #(.WIDTH(ENTRY_W), .DEPTH(CLIENT_ENTRIES)) u_cli_ram (
    .clk   (clk),
    .we    (wr_cli && cli_hit),
    .waddr (cli_addr),
    .wdata (wentry),
    .re    (rd && !dir),
    .raddr (cli_addr),
    .rdata (cli_rdata)
  );

  assign looked = pend_hit ? (pend_dir ? srv_rdata : cli_rdata) : '0;
  assign entry  = pend ? looked : chosen;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 1'b0;
      pend_dir <= 1'b0;
      pend_hit <= 1'b0;
      chosen   <= '0;
    end else begin
      pend <= rd;
      if (rd) begin
        pend_dir <= dir;
        pend_hit <= dir ? srv_hit : cli_hit;
      end
      if (pend) begin
        chosen <= looked;
      end
    end
  end

  a_pend_after_read: assert property (@(posedge clk) disable iff (rst)
    pend |-> $past(rd))
    else $error("lookup pending without a read");

  a_entry_latched: assert property (@(posedge clk) disable iff (rst)
    pend |=> chosen == $past(looked))
    else $error("looked-up entry not latched");

endmodule

>>> hdl/tnhr_acc.sv
// ----------------------------------------------------------------------------
// tnhr_acc
// Per-beat header capture and running ones-complement sums.
// ----------------------------------------------------------------------------
module tnhr_acc import tnhr_pkg::*; #(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              beat,
  input  logic              last,
  input  logic [BYTE_W-1:0] data_byte,
  output logic              first,
  output pkt_sum_t          summary
);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [LEN_W-1:0] tot_len;
  logic [LEN_W-1:0] tot_len_next;
  logic [HW_W-1:0]  hdr_words;
  logic [HW_W-1:0]  hdr_words_next;
  logic [7:0]       hold;
  logic [7:0]       hold_next;
  logic [IPS_W-1:0] ip_sum;
  logic [IPS_W-1:0] ip_sum_next;
  logic [TCS_W-1:0] tcp_sum;
  logic [TCS_W-1:0] tcp_sum_next;
  logic [LIM_W-1:0] tcp_limit;
  logic             counting;
  logic             at_start;
  logic             in_tcp;
  logic [15:0]      placed;
  logic [IPS_W-1:0] ip_base;
  logic [TCS_W-1:0] tcp_base;
  logic [POS_W-1:0] pos_inc;

  assign counting = (32'(pos) < MAX_PACKET_BYTES);
  assign at_start = (32'(pos) == POS_VER_IHL);
  assign first    = beat && at_start;
  assign placed   = pos[0] ? {8'h00, data_byte} : {data_byte, 8'h00};
  assign ip_base  = at_start ? '0 : ip_sum;
  assign tcp_base = at_start ? '0 : tcp_sum;
  assign in_tcp   = (32'(pos) >= TCP_SUM_START) && (LIM_W'(pos) < tcp_limit)
                    && (32'(pos) != TCP_CSUM_HI) && (32'(pos) != TCP_CSUM_LO);
  assign pos_inc  = counting ? pos + POS_W'(1) : pos;

  always_comb begin
    pos_next       = pos;
    tot_len_next   = tot_len;
    hdr_words_next = hdr_words;
    hold_next      = hold;
    ip_sum_next    = ip_sum;
    tcp_sum_next   = tcp_sum;
    if (beat && counting) begin
      pos_next       = pos_inc;
      tot_len_next   = at_start ? '0 : tot_len;
      hdr_words_next = at_start ? data_byte[HW_W-1:0] : hdr_words;
      hold_next      = at_start ? '0 : hold;
      if (32'(pos) == POS_LEN_HI) begin
        hold_next = data_byte;
      end
      if (32'(pos) == POS_LEN_LO) begin
        tot_len_next = {hold, data_byte};
      end
      ip_sum_next  = (32'(pos) < IP_SUM_END) ? ip_base + IPS_W'(placed) : ip_base;
      tcp_sum_next = in_tcp ? tcp_base + TCS_W'(placed) : tcp_base;
    end
    if (beat && last) begin
      pos_next = '0;
    end
  end

  assign summary.ip_sum    = ip_sum_next;
  assign summary.tcp_sum   = tcp_sum_next;
  assign summary.tot_len   = tot_len_next;
  assign summary.hdr_words = hdr_words_next;
  assign summary.count     = LEN_W'(pos_inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      tot_len   <= '0;
      hdr_words <= '0;
      hold      <= '0;
      ip_sum    <= '0;
      tcp_sum   <= '0;
      tcp_limit <= '0;
    end else begin
      pos       <= pos_next;
      tot_len   <= tot_len_next;
      hdr_words <= hdr_words_next;
      hold      <= hold_next;
      ip_sum    <= ip_sum_next;
      tcp_sum   <= tcp_sum_next;
      tcp_limit <= LIM_W'(IP_HDR_BYTES) + LIM_W'(tcp_len(tot_len, hdr_words));
    end
  end

  a_pos_cleared: assert property (@(posedge clk) disable iff (rst)
    beat && last |=> pos == '0)
    else $error("position not cleared after last beat");

  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    beat && !last && counting |=> pos == $past(pos) + POS_W'(1))
    else $error("position did not advance");

endmodule

>>> hdl/tnhr_fin.sv
// ----------------------------------------------------------------------------
// tnhr_fin
// Result pipeline: fold, add rewritten fields and pseudo header, complement.
// ----------------------------------------------------------------------------
module tnhr_fin import tnhr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pkt_sum_t           summary,
  input  logic [ENTRY_W-1:0] entry,
  input  logic [IP_W-1:0]    bal_ip,
  input  logic [PORT_W-1:0]  bal_port,
  output logic               out_valid,
  input  logic               out_ready,
  output result_t            result
);

  logic v1, v2, v3, vo;
  logic r1, r2, r3, ro;

  pkt_sum_t          s1;

  logic [16:0]       ip2;
  logic [16:0]       tcp2;
  logic [LEN_W-1:0]  tl2;
  logic              short2;
  logic [IP_W-1:0]   sip2, dip2;
  logic [PORT_W-1:0] sport2, dport2;

  logic [20:0]       ip3;
  logic [20:0]       tcp3;
  logic              short3;
  logic [IP_W-1:0]   sip3, dip3;
  logic [PORT_W-1:0] sport3, dport3;

  logic [LEN_W-1:0]  tl1;
  logic [20:0]       ip_tot;
  logic [20:0]       tcp_tot;
  logic [16:0]       ip_fa, tcp_fa;
  logic [15:0]       ip_fb, tcp_fb;

  assign ro       = !vo || out_ready;
  assign r3       = !v3 || ro;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;
  assign out_valid = vo;

  assign tl1 = tcp_len(s1.tot_len, s1.hdr_words);

  always_comb begin
    ip_tot = 21'(ip2) + 21'(sip2[31:16]) + 21'(sip2[15:0])
             + 21'(dip2[31:16]) + 21'(dip2[15:0]);
    tcp_tot = 21'(tcp2) + 21'(sip2[31:16]) + 21'(sip2[15:0])
              + 21'(dip2[31:16]) + 21'(dip2[15:0]) + 21'(TCP_PROTO) + 21'(tl2);
    if (tl2 > 16'd0) tcp_tot = tcp_tot + 21'({sport2[15:8], 8'h00});
    if (tl2 > 16'd1) tcp_tot = tcp_tot + 21'(sport2[7:0]);
    if (tl2 > 16'd2) tcp_tot = tcp_tot + 21'({dport2[15:8], 8'h00});
    if (tl2 > 16'd3) tcp_tot = tcp_tot + 21'(dport2[7:0]);
  end

  assign ip_fa  = 17'(ip3[15:0]) + 17'(ip3[20:16]);
  assign ip_fb  = ip_fa[15:0] + 16'(ip_fa[16]);
  assign tcp_fa = 17'(tcp3[15:0]) + 17'(tcp3[20:16]);
  assign tcp_fb = tcp_fa[15:0] + 16'(tcp_fa[16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (ro) vo <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      s1 <= summary;
    end
    if (r2 && v1) begin
      ip2    <= 17'(s1.ip_sum[15:0]) + 17'(s1.ip_sum[IPS_W-1:16]);
      tcp2   <= 17'(s1.tcp_sum[15:0]) + 17'(s1.tcp_sum[TCS_W-1:16]);
      tl2    <= tl1;
      short2 <= LIM_W'(s1.count) < (LIM_W'(IP_HDR_BYTES) + LIM_W'(tl1));
      sip2   <= bal_ip;
      dip2   <= entry[ENTRY_W-1:PORT_W];
      sport2 <= bal_port;
      dport2 <= entry[PORT_W-1:0];
    end
    if (r3 && v2) begin
      ip3    <= ip_tot;
      tcp3   <= tcp_tot;
      short3 <= short2;
      sip3   <= sip2;
      dip3   <= dip2;
      sport3 <= sport2;
      dport3 <= dport2;
    end
    if (ro && v3) begin
      result.src_ip    <= sip3;
      result.dst_ip    <= dip3;
      result.src_port  <= sport3;
      result.dst_port  <= dport3;
      result.ip_csum   <= ONES16 & ~ip_fb;
      result.tcp_csum  <= ONES16 & ~tcp_fb;
      result.short_pkt <= short3;
    end
  end

  a_hold_stage3: assert property (@(posedge clk) disable iff (rst)
    v3 && vo && !out_ready |=> v3 && vo)
    else $error("result lost while output stalled");

  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> v1 && v2 && v3 && vo)
    else $error("input stalled with a free stage");

endmodule
